// ===== rtl/core/fss_pkg.sv =====
// Package of the FAT16 sector synthesizer: register codes, shared types and volume constants.
package fss_pkg;

	localparam int unsigned SECTOR_BYTES = 512;

	// Configuration register codes, in write-port index order
	typedef enum logic [2:0] {
		REG_RESERVED_SECTORS = 3'd0,
		REG_FAT_COPIES       = 3'd1,
		REG_FAT_SECTORS      = 3'd2,
		REG_ROOT_ENTRIES     = 3'd3,
		REG_TOTAL_SECTORS    = 3'd4,
		REG_LAST_CLUSTER     = 3'd5,
		REG_MEMORY_BASE      = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [6:0]  reserved_sectors;
		logic [1:0]  fat_copies;
		logic [8:0]  fat_sectors;
		logic [10:0] root_entries;
		logic [15:0] total_sectors;
		logic [15:0] last_cluster;
		logic [31:0] memory_base;
	} cfg_t;

	typedef struct packed {
		logic [31:0] memory_address;
		logic        from_memory;
		logic [7:0]  byte_value;
	} result_t;

	// Reset values of the volume geometry
	localparam logic [6:0]  RESET_RESERVED_SECTORS = 7'd1;
	localparam logic [1:0]  RESET_FAT_COPIES       = 2'd1;
	localparam logic [8:0]  RESET_FAT_SECTORS      = 9'd16;
	localparam logic [10:0] RESET_ROOT_ENTRIES     = 11'd512;
	localparam logic [15:0] RESET_TOTAL_SECTORS    = 16'd4096;
	localparam logic [15:0] RESET_LAST_CLUSTER     = 16'd2049;
	localparam logic [31:0] RESET_MEMORY_BASE      = 32'h0200_0000;

	// Fixed volume contents
	localparam logic [7:0]  MEDIA_MARK      = 8'hF8;
	localparam logic [15:0] FAT_MEDIA_ENTRY = 16'hFFF8;
	localparam logic [15:0] FAT_EOC         = 16'hFFFF;
	localparam logic [31:0] VOLUME_SERIAL   = 32'h52A8_D200;
	localparam logic [31:0] FILE_BYTES      = 32'h0010_0000;
	localparam logic [15:0] FIRST_CLUSTER   = 16'd2;

	// Strings pack their first character in the top byte
	localparam logic [63:0] OEM_TEXT   = "VDISK   ";
	localparam logic [87:0] LABEL_TEXT = "VIRTUALDISK";
	localparam logic [63:0] FS_TEXT    = "FAT16   ";
	localparam logic [87:0] FILE_TEXT  = "DATA    BIN";

endpackage

// ===== rtl/core/fss_cfg.sv =====
// Configuration register file of the FAT16 sector synthesizer.
module fss_cfg
	import fss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reserved_sectors <= RESET_RESERVED_SECTORS;
			cfg_q.fat_copies       <= RESET_FAT_COPIES;
			cfg_q.fat_sectors      <= RESET_FAT_SECTORS;
			cfg_q.root_entries     <= RESET_ROOT_ENTRIES;
			cfg_q.total_sectors    <= RESET_TOTAL_SECTORS;
			cfg_q.last_cluster     <= RESET_LAST_CLUSTER;
			cfg_q.memory_base      <= RESET_MEMORY_BASE;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_RESERVED_SECTORS: cfg_q.reserved_sectors <= cfg_data[6:0];
				REG_FAT_COPIES:       cfg_q.fat_copies       <= cfg_data[1:0];
				REG_FAT_SECTORS:      cfg_q.fat_sectors      <= cfg_data[8:0];
				REG_ROOT_ENTRIES:     cfg_q.root_entries     <= cfg_data[10:0];
				REG_TOTAL_SECTORS:    cfg_q.total_sectors    <= cfg_data[15:0];
				REG_LAST_CLUSTER:     cfg_q.last_cluster     <= cfg_data[15:0];
				REG_MEMORY_BASE:      cfg_q.memory_base      <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/fss_byte.sv =====
// Combinational byte generator: region decode, boot, FAT, root and data-region bytes.
module fss_byte
	import fss_pkg::*;
(
	input  cfg_t        cfg,
	input  logic [15:0] sector_address,
	input  logic [8:0]  byte_offset,
	output result_t     result
);

	logic [10:0] fat_span;
	logic [16:0] fat_lba;
	logic [16:0] root_lba;
	logic [16:0] data_lba;
	logic [7:0]  root_secs;
	logic [16:0] lba_x;
	logic [16:0] fat_rel;
	logic [16:0] fs_one;
	logic [16:0] fs_two;
	logic [16:0] fsec_w;
	logic [16:0] entry;
	logic [16:0] entry_inc;
	logic [15:0] fat_val;
	logic [7:0]  boot_b;
	logic [7:0]  fat_b;
	logic [7:0]  root_b;
	logic [3:0]  idx_a;
	logic [3:0]  idx_b;
	logic [3:0]  idx_c;
	logic [16:0] data_rel;
	logic        in_chain;
	logic [31:0] data_addr;

	// Volume layout
	assign fat_span  = 11'(cfg.fat_copies * cfg.fat_sectors);
	assign root_secs = 8'((12'(cfg.root_entries) + 12'd15) >> 4);
	assign fat_lba   = 17'(cfg.reserved_sectors);
	assign root_lba  = fat_lba + 17'(fat_span);
	assign data_lba  = root_lba + 17'(root_secs);
	assign lba_x     = 17'(sector_address);

	// Fold the copy index away: at most three copies, so two compares suffice
	assign fat_rel = lba_x - fat_lba;
	assign fs_one  = 17'(cfg.fat_sectors);
	assign fs_two  = fs_one << 1;
	always_comb begin
		if (fat_rel >= fs_two) begin
			fsec_w = fat_rel - fs_two;
		end else if (fat_rel >= fs_one) begin
			fsec_w = fat_rel - fs_one;
		end else begin
			fsec_w = fat_rel;
		end
	end

	assign entry     = {fsec_w[8:0], byte_offset[8:1]};
	assign entry_inc = entry + 17'd1;

	always_comb begin
		if (entry == 17'd0) begin
			fat_val = FAT_MEDIA_ENTRY;
		end else if (entry == 17'd1) begin
			fat_val = FAT_EOC;
		end else if (entry < 17'(cfg.last_cluster)) begin
			fat_val = entry_inc[15:0];
		end else if (entry == 17'(cfg.last_cluster)) begin
			fat_val = FAT_EOC;
		end else begin
			fat_val = 16'd0;
		end
	end
	assign fat_b = byte_offset[0] ? fat_val[15:8] : fat_val[7:0];

	// String character indexes
	assign idx_a = 4'(byte_offset - 9'd3);
	assign idx_b = 4'(byte_offset - 9'd43);
	assign idx_c = 4'(byte_offset - 9'd54);

	always_comb begin
		boot_b = 8'h00;
		if (byte_offset >= 9'd3 && byte_offset < 9'd11) begin
			boot_b = OEM_TEXT[8 * (7 - idx_a[2:0]) +: 8];
		end else if (byte_offset >= 9'd43 && byte_offset < 9'd54) begin
			boot_b = LABEL_TEXT[8 * (10 - int'(idx_b)) +: 8];
		end else if (byte_offset >= 9'd54 && byte_offset < 9'd62) begin
			boot_b = FS_TEXT[8 * (7 - idx_c[2:0]) +: 8];
		end else begin
			case (byte_offset)
				9'd0:   boot_b = 8'hEB;
				9'd1:   boot_b = 8'h3C;
				9'd2:   boot_b = 8'h90;
				9'd11:  boot_b = 8'(SECTOR_BYTES & 255);
				9'd12:  boot_b = 8'(SECTOR_BYTES >> 8);
				9'd13:  boot_b = 8'h01;
				9'd14:  boot_b = {1'b0, cfg.reserved_sectors};
				9'd16:  boot_b = {6'd0, cfg.fat_copies};
				9'd17:  boot_b = cfg.root_entries[7:0];
				9'd18:  boot_b = {5'd0, cfg.root_entries[10:8]};
				9'd19:  boot_b = cfg.total_sectors[7:0];
				9'd20:  boot_b = cfg.total_sectors[15:8];
				9'd21:  boot_b = MEDIA_MARK;
				9'd22:  boot_b = cfg.fat_sectors[7:0];
				9'd23:  boot_b = {7'd0, cfg.fat_sectors[8]};
				9'd24:  boot_b = 8'd32;
				9'd26:  boot_b = 8'd16;
				9'd36:  boot_b = 8'h80;
				9'd38:  boot_b = 8'h29;
				9'd39:  boot_b = VOLUME_SERIAL[7:0];
				9'd40:  boot_b = VOLUME_SERIAL[15:8];
				9'd41:  boot_b = VOLUME_SERIAL[23:16];
				9'd42:  boot_b = VOLUME_SERIAL[31:24];
				9'd510: boot_b = 8'h55;
				9'd511: boot_b = 8'hAA;
				default: boot_b = 8'h00;
			endcase
		end
	end

	// Only the first root sector holds entries
	always_comb begin
		root_b = 8'h00;
		if (lba_x == root_lba) begin
			if (byte_offset < 9'd11) begin
				root_b = LABEL_TEXT[8 * (10 - int'(byte_offset[3:0])) +: 8];
			end else if (byte_offset >= 9'd32 && byte_offset < 9'd43) begin
				root_b = FILE_TEXT[8 * (10 - int'(byte_offset[3:0])) +: 8];
			end else begin
				case (byte_offset)
					9'd11: root_b = 8'h08;
					9'd43: root_b = 8'h01;
					9'd58: root_b = FIRST_CLUSTER[7:0];
					9'd59: root_b = FIRST_CLUSTER[15:8];
					9'd60: root_b = FILE_BYTES[7:0];
					9'd61: root_b = FILE_BYTES[15:8];
					9'd62: root_b = FILE_BYTES[23:16];
					9'd63: root_b = FILE_BYTES[31:24];
					default: root_b = 8'h00;
				endcase
			end
		end
	end

	// Data region: one sector per cluster, chain ends at last_cluster
	assign data_rel  = lba_x - data_lba;
	assign in_chain  = (cfg.last_cluster >= FIRST_CLUSTER) &&
		((data_rel + 17'(FIRST_CLUSTER)) <= 17'(cfg.last_cluster));
	assign data_addr = cfg.memory_base + {7'd0, data_rel[15:0], byte_offset};

	always_comb begin
		result = '0;
		if (sector_address == 16'd0) begin
			result.byte_value = boot_b;
		end else if (lba_x < fat_lba) begin
			result.byte_value = 8'h00;
		end else if (lba_x < root_lba) begin
			result.byte_value = fat_b;
		end else if (lba_x < data_lba) begin
			result.byte_value = root_b;
		end else if (in_chain) begin
			result.from_memory    = 1'b1;
			result.memory_address = data_addr;
		end
	end

endmodule

// ===== rtl/core/fat16_sector_synthesizer.sv =====
// Top level of the FAT16 sector synthesizer: config port, request and result registers.
//
// Read-only virtual FAT16 disk. Each request on the s_axis channel carries a
// sector address and a byte offset; each result on m_axis carries the byte of
// the synthesized volume, or a flag and a backing-memory address for bytes of
// the data region.
//
// Channels: s_axis (requests in), m_axis (results out), one result per request,
// in request order. Geometry registers are written through cfg_wr_en, cfg_index and
// cfg_data by the user only while no request is in flight; the block does not check it.
//
// Timing: the request register loads at the accepting edge and the result
// register loads from it whenever the result stage is empty or draining.
// Throughput: one request per cycle while m_axis_tready stays high, bounded by the
// combinational byte decode between the registers.
//
// Reset: arst_n clears both valid flags and loads the default geometry
// (one reserved sector, one 16-sector FAT, 512 root entries).
// Stall: while m_axis_tready is low the result holds; the request register
// still fills, and s_axis_tready drops only when both stages are full.
module fat16_sector_synthesizer
	import fss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Request channel
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] sector_address, [24:16] byte_offset
	// Result channel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [7:0] byte_value, [8] from_memory,
	                                   // [40:9] memory_address
);

	cfg_t        cfg;
	logic        valid_s1;
	logic [15:0] lba_s1;
	logic [8:0]  off_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     result_c;
	logic        adv_s1;

	fss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the request stage whenever the result stage is empty or draining
	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload: capture request fields, hold while stalled
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			lba_s1 <= s_axis_tdata[15:0];
			off_s1 <= s_axis_tdata[24:16];
		end
		if (adv_s1 && valid_s1) begin
			result_s2 <= result_c;
		end
	end

	fss_byte u_byte (
		.cfg            (cfg),
		.sector_address (lba_s1),
		.byte_offset    (off_s1),
		.result         (result_c)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, result_s2.memory_address, result_s2.from_memory,
		result_s2.byte_value};

endmodule

// ===== rtl/core/fss_checker.sv =====
// Port-level checker of the FAT16 sector synthesizer, with its bind.
module fss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A synthesized byte never carries an address, a fetch never carries a byte
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[40:9] == 32'd0)
		else $error("address set without fetch");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("byte set on fetch");

	// A request followed by a free receiver yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("request lost in pipeline");

endmodule

bind fat16_sector_synthesizer fss_checker u_fss_checker (.*);
